>>> hw/rtl/slc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sphere light table package
// Shared sizes, codes and payload types of the light table and its query
// pipeline.
// ---------------------------------------------------------------------------
package slc_pkg;

   // Table and match limits.
   localparam int MAX_LIGHTS  = 64;
   localparam int MAX_MATCHES = 4;

   // Derived widths.
   localparam int IDX_W  = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
   localparam int CNT_W  = $clog2(MAX_LIGHTS + 1);
   localparam int MIDX_W = (MAX_MATCHES > 1) ? $clog2(MAX_MATCHES) : 1;
   localparam int MCNT_W = $clog2(MAX_MATCHES + 1);

   // Fixed field widths.
   localparam int COORD_W = 24;
   localparam int SLOT_W  = 6;
   localparam int LCNT_W  = 7;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_QUERY  = 2'd3
   } op_code_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      op_code_type               req_type;
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] center_z;
      logic [COORD_W-1:0]        sphere_radius;
      logic                      enabled_flag;
      logic                      night_only_flag;
      logic [5:0]                entry_index;
   } slc_req_type;

   typedef struct packed {
      status_code_type   status;
      logic [SLOT_W-1:0] slot_index;
      logic              match_valid;
      logic [LCNT_W-1:0] light_count;
      logic              last_result;
   } slc_rsp_type;

   // One table entry as stored in memory.
   typedef struct packed {
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] center_z;
      logic [COORD_W-1:0]        radius;
      logic                      enabled;
      logic                      night_only;
   } light_type;

endpackage

>>> hw/rtl/slc_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module slc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/slc_overlap.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sphere overlap pipeline
// Two register stages: per-axis distance and reach, then squares. The
// compare of squared distance against squared reach follows the last stage.
// ---------------------------------------------------------------------------
module slc_overlap (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [slc_pkg::IDX_W-1:0] in_idx,
   input  slc_pkg::light_type        light,
   input  slc_pkg::slc_req_type      query,
   input  logic                      night_mode,
   output logic                      out_valid,
   output logic [slc_pkg::IDX_W-1:0] out_idx,
   output logic                      out_hit,
   output logic                      busy
);

   localparam int W   = slc_pkg::COORD_W;
   localparam int SQ_W = 2 * W;

   // Stage A: absolute differences and reach.
   logic            sa_valid_ff, sa_valid_in;
   logic [slc_pkg::IDX_W-1:0] sa_idx_ff;
   logic            sa_elig_ff, sa_elig_in;
   logic [W-1:0]    sa_dx_ff, sa_dy_ff, sa_dz_ff;
   logic [W-1:0]    sa_dx_in, sa_dy_in, sa_dz_in;
   logic [W:0]      sa_reach_ff, sa_reach_in;

   // Stage B: squares.
   logic            sb_valid_ff, sb_valid_in;
   logic [slc_pkg::IDX_W-1:0] sb_idx_ff;
   logic            sb_elig_ff;
   logic [SQ_W-1:0] sb_sx_ff, sb_sy_ff, sb_sz_ff;
   logic [SQ_W+1:0] sb_reach2_ff;

   logic signed [W:0] dx, dy, dz;
   logic [SQ_W+1:0]   dist2;

   always_comb begin
      dx = {query.center_x[W-1], query.center_x} - {light.center_x[W-1], light.center_x};
      dy = {query.center_y[W-1], query.center_y} - {light.center_y[W-1], light.center_y};
      dz = {query.center_z[W-1], query.center_z} - {light.center_z[W-1], light.center_z};
      // The magnitude of a difference of two 24-bit values stays below 2^24.
      sa_dx_in    = dx[W] ? W'(-dx) : W'(dx);
      sa_dy_in    = dy[W] ? W'(-dy) : W'(dy);
      sa_dz_in    = dz[W] ? W'(-dz) : W'(dz);
      sa_reach_in = {1'b0, query.sphere_radius} + {1'b0, light.radius};
      sa_elig_in  = light.enabled && (!light.night_only || night_mode);
      sa_valid_in = in_valid;
      sb_valid_in = sa_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_valid_ff <= 1'b0;
         sb_valid_ff <= 1'b0;
      end else begin
         sa_valid_ff <= sa_valid_in;
         sb_valid_ff <= sb_valid_in;
      end
      sa_idx_ff    <= in_idx;
      sa_elig_ff   <= sa_elig_in;
      sa_dx_ff     <= sa_dx_in;
      sa_dy_ff     <= sa_dy_in;
      sa_dz_ff     <= sa_dz_in;
      sa_reach_ff  <= sa_reach_in;
      sb_idx_ff    <= sa_idx_ff;
      sb_elig_ff   <= sa_elig_ff;
      sb_sx_ff     <= sa_dx_ff * sa_dx_ff;
      sb_sy_ff     <= sa_dy_ff * sa_dy_ff;
      sb_sz_ff     <= sa_dz_ff * sa_dz_ff;
      sb_reach2_ff <= sa_reach_ff * sa_reach_ff;
   end

   assign dist2     = (SQ_W+2)'(sb_sx_ff) + (SQ_W+2)'(sb_sy_ff) + (SQ_W+2)'(sb_sz_ff);
   assign out_valid = sb_valid_ff;
   assign out_idx   = sb_idx_ff;
   assign out_hit   = sb_elig_ff && (dist2 <= sb_reach2_ff);
   assign busy      = sa_valid_ff || sb_valid_ff;

endmodule

>>> hw/rtl/sphere_light_table_cull.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sphere light table cull
// Keeps a packed table of point lights in one RAM and answers add, remove,
// clear and sphere overlap queries, one request at a time.
// ---------------------------------------------------------------------------
// Add, clear and a rejected remove pass straight to the result state once accepted.
// A remove at index i moves the tail down one entry per cycle, then shows its result.
// A query reads one entry per cycle until the end of the table or the match limit,
// then shows its results one per cycle while the consumer does not stall. Throughput:
// one request in flight, the next is taken when idle. Reset: synchronous, active high;
// empties the table and clears night mode.
module sphere_light_table_cull (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  slc_pkg::slc_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output slc_pkg::slc_rsp_type rsp_data,
   input  logic                 csr_write_enable,
   input  logic                 csr_write_data
);

   localparam int IDX_W  = slc_pkg::IDX_W;
   localparam int CNT_W  = slc_pkg::CNT_W;
   localparam int MIDX_W = slc_pkg::MIDX_W;
   localparam int MCNT_W = slc_pkg::MCNT_W;

   // Control state.
   slc_pkg::state_type   state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     ptr_ff, ptr_in;
   logic [MCNT_W-1:0]    found_n_ff, found_n_in;
   logic [MCNT_W-1:0]    drain_ff, drain_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 night_mode_ff, night_mode_in;

   // Payload state.
   logic [IDX_W-1:0]     found_ff [slc_pkg::MAX_MATCHES];
   logic [IDX_W-1:0]     found_in [slc_pkg::MAX_MATCHES];
   logic [IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   slc_pkg::slc_req_type req_ff, req_in;
   slc_pkg::status_code_type pend_status_ff, pend_status_in;
   logic [slc_pkg::SLOT_W-1:0] pend_slot_ff, pend_slot_in;
   slc_pkg::slc_rsp_type rsp_data_ff, rsp_data_in;

   // RAM port signals.
   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   slc_pkg::light_type   ram_wdata;
   slc_pkg::light_type   ram_rdata;

   // Overlap pipeline signals.
   logic                 hit_valid;
   logic [IDX_W-1:0]     hit_idx;
   logic                 hit;
   logic                 ovl_busy;

   // Status terms.
   logic req_accept;
   logic in_range;
   logic table_full;
   logic matches_full;
   logic more_entries;
   logic scan_done;
   logic shift_done;
   logic drain_last;
   logic out_free;
   logic issue_read;
   logic rsp_load;

   assign req_accept   = req_valid && !req_stall;
   assign in_range     = CNT_W'(req_data.entry_index) < count_ff;
   assign table_full   = count_ff == CNT_W'(slc_pkg::MAX_LIGHTS);
   assign matches_full = found_n_ff == MCNT_W'(slc_pkg::MAX_MATCHES);
   assign more_entries = ptr_ff < count_ff;
   // The scan ends when no further reads are due and every read has passed
   // through the overlap pipeline and been recorded.
   assign scan_done    = (!more_entries || matches_full) && !rd_valid_ff && !ovl_busy;
   assign shift_done   = !more_entries && !rd_valid_ff;
   assign drain_last   = (found_n_ff == '0) || (MCNT_W'(drain_ff + 1'b1) == found_n_ff);
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   slc_ram #(
      .WIDTH ($bits(slc_pkg::light_type)),
      .DEPTH (slc_pkg::MAX_LIGHTS)
   ) u_light_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ptr_ff[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   slc_overlap u_overlap (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (rd_valid_ff && (state_ff == slc_pkg::ST_SCAN)),
      .in_idx     (rd_idx_ff),
      .light      (ram_rdata),
      .query      (req_ff),
      .night_mode (night_mode_ff),
      .out_valid  (hit_valid),
      .out_idx    (hit_idx),
      .out_hit    (hit),
      .busy       (ovl_busy)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         slc_pkg::ST_IDLE: begin
            if (req_accept) begin
               unique case (req_data.req_type)
                  slc_pkg::OP_ADD:    state_in = slc_pkg::ST_EMIT;
                  slc_pkg::OP_REMOVE: state_in = in_range ? slc_pkg::ST_SHIFT
                                                          : slc_pkg::ST_EMIT;
                  slc_pkg::OP_CLEAR:  state_in = slc_pkg::ST_EMIT;
                  slc_pkg::OP_QUERY:  state_in = slc_pkg::ST_SCAN;
                  default:            state_in = slc_pkg::ST_EMIT;
               endcase
            end
         end
         slc_pkg::ST_SCAN: begin
            if (scan_done) state_in = slc_pkg::ST_DRAIN;
         end
         slc_pkg::ST_SHIFT: begin
            if (shift_done) state_in = slc_pkg::ST_EMIT;
         end
         slc_pkg::ST_DRAIN: begin
            if (out_free && drain_last) state_in = slc_pkg::ST_IDLE;
         end
         slc_pkg::ST_EMIT: begin
            if (out_free) state_in = slc_pkg::ST_IDLE;
         end
         default: state_in = slc_pkg::ST_IDLE;
      endcase
   end

   // State machine outputs: handshake, RAM reads and writes, result loads.
   always_comb begin
      req_stall  = 1'b1;
      issue_read = 1'b0;
      rsp_load   = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = count_ff[IDX_W-1:0];
      ram_wdata  = '{center_x:   req_data.center_x,
                     center_y:   req_data.center_y,
                     center_z:   req_data.center_z,
                     radius:     req_data.sphere_radius,
                     enabled:    req_data.enabled_flag,
                     night_only: req_data.night_only_flag};
      unique case (state_ff)
         slc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            // An add writes its entry at the current end of the table.
            ram_we = req_valid && (req_data.req_type == slc_pkg::OP_ADD) && !table_full;
         end
         slc_pkg::ST_SCAN: begin
            issue_read = more_entries && !matches_full;
         end
         slc_pkg::ST_SHIFT: begin
            // Each entry read in the previous cycle moves down by one place. Reads
            // run ahead of writes, so the two never touch the same entry.
            issue_read = more_entries;
            ram_we     = rd_valid_ff;
            ram_waddr  = IDX_W'(rd_idx_ff - 1'b1);
            ram_wdata  = ram_rdata;
         end
         slc_pkg::ST_DRAIN: begin
            rsp_load = out_free;
         end
         slc_pkg::ST_EMIT: begin
            rsp_load = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      count_in       = count_ff;
      ptr_in         = ptr_ff;
      found_n_in     = found_n_ff;
      drain_in       = drain_ff;
      found_in       = found_ff;
      req_in         = req_ff;
      pend_status_in = pend_status_ff;
      pend_slot_in   = pend_slot_ff;
      night_mode_in  = csr_write_enable ? csr_write_data : night_mode_ff;
      rd_valid_in    = issue_read;
      rd_idx_in      = ptr_ff[IDX_W-1:0];
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;

      if (issue_read) begin
         ptr_in = CNT_W'(ptr_ff + 1'b1);
      end

      if (req_accept) begin
         req_in         = req_data;
         pend_status_in = slc_pkg::STATUS_OK;
         pend_slot_in   = '0;
         unique case (req_data.req_type)
            slc_pkg::OP_ADD: begin
               if (table_full) begin
                  pend_status_in = slc_pkg::STATUS_FULL;
               end else begin
                  pend_slot_in = slc_pkg::SLOT_W'(count_ff);
                  count_in     = CNT_W'(count_ff + 1'b1);
               end
            end
            slc_pkg::OP_REMOVE: begin
               if (in_range) begin
                  ptr_in = CNT_W'(CNT_W'(req_data.entry_index) + 1'b1);
               end else begin
                  pend_status_in = slc_pkg::STATUS_RANGE;
               end
            end
            slc_pkg::OP_CLEAR: begin
               count_in = '0;
            end
            slc_pkg::OP_QUERY: begin
               ptr_in     = '0;
               found_n_in = '0;
               drain_in   = '0;
            end
            default: begin
               pend_status_in = slc_pkg::STATUS_OK;
            end
         endcase
      end

      if ((state_ff == slc_pkg::ST_SHIFT) && shift_done) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end

      // Matches arrive in table order; anything past the limit is dropped.
      if ((state_ff == slc_pkg::ST_SCAN) && hit_valid && hit && !matches_full) begin
         found_in[found_n_ff[MIDX_W-1:0]] = hit_idx;
         found_n_in = MCNT_W'(found_n_ff + 1'b1);
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         if (state_ff == slc_pkg::ST_DRAIN) begin
            rsp_data_in.status      = slc_pkg::STATUS_OK;
            rsp_data_in.slot_index  = (found_n_ff != '0)
                                      ? slc_pkg::SLOT_W'(found_ff[drain_ff[MIDX_W-1:0]])
                                      : '0;
            rsp_data_in.match_valid = found_n_ff != '0;
            rsp_data_in.last_result = drain_last;
            drain_in                = MCNT_W'(drain_ff + 1'b1);
         end else begin
            rsp_data_in.status      = pend_status_ff;
            rsp_data_in.slot_index  = pend_slot_ff;
            rsp_data_in.match_valid = 1'b0;
            rsp_data_in.last_result = 1'b1;
         end
         rsp_data_in.light_count = slc_pkg::LCNT_W'(count_ff);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= slc_pkg::ST_IDLE;
         count_ff      <= '0;
         ptr_ff        <= '0;
         found_n_ff    <= '0;
         drain_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         night_mode_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         ptr_ff        <= ptr_in;
         found_n_ff    <= found_n_in;
         drain_ff      <= drain_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         night_mode_ff <= night_mode_in;
      end
      found_ff       <= found_in;
      rd_idx_ff      <= rd_idx_in;
      req_ff         <= req_in;
      pend_status_ff <= pend_status_in;
      pend_slot_ff   <= pend_slot_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> tb/light_table_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Light table checker
// Watches the request, result and register ports of the light table, keeps
// its own copy of the table and the night flag, and compares every result
// with the one predicted for it.
// ---------------------------------------------------------------------------
module light_table_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  slc_pkg::slc_req_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  slc_pkg::slc_rsp_type rsp_data,
   input  logic                 csr_write_enable,
   input  logic                 csr_write_data,
   output int                   fail_count,
   output int                   pending_results,
   output int                   checked_results
);
   import slc_pkg::*;

   light_type   lights [MAX_LIGHTS];
   int unsigned light_total;
   logic        night_on;
   slc_rsp_type awaited_rsp_q [$];

   function automatic longint sq_gap(logic signed [COORD_W-1:0] a,
                                     logic signed [COORD_W-1:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      return d * d;
   endfunction

   function automatic void post_reply(status_code_type st, int unsigned slot,
                                      bit hit, bit last);
      slc_rsp_type r;
      r.status      = st;
      r.slot_index  = slot[SLOT_W-1:0];
      r.match_valid = hit;
      r.light_count = light_total[LCNT_W-1:0];
      r.last_result = last;
      awaited_rsp_q.push_back(r);
   endfunction

   // Applies one request to the shadow table and queues the results it causes.
   function automatic void replay_light_request(slc_req_type r);
      int unsigned idx;
      int unsigned hits;
      int unsigned found [MAX_MATCHES];
      longint      gap2;
      longint      reach;
      case (r.req_type)
         OP_ADD: begin
            if (light_total >= MAX_LIGHTS) begin
               post_reply(STATUS_FULL, 0, 1'b0, 1'b1);
            end else begin
               lights[light_total].center_x   = r.center_x;
               lights[light_total].center_y   = r.center_y;
               lights[light_total].center_z   = r.center_z;
               lights[light_total].radius     = r.sphere_radius;
               lights[light_total].enabled    = r.enabled_flag;
               lights[light_total].night_only = r.night_only_flag;
               light_total++;
               post_reply(STATUS_OK, light_total - 1, 1'b0, 1'b1);
            end
         end
         OP_REMOVE: begin
            idx = r.entry_index;
            if (idx >= light_total) begin
               post_reply(STATUS_RANGE, 0, 1'b0, 1'b1);
            end else begin
               for (int unsigned i = idx; i + 1 < light_total; i++) begin
                  lights[i] = lights[i + 1];
               end
               light_total--;
               post_reply(STATUS_OK, 0, 1'b0, 1'b1);
            end
         end
         OP_CLEAR: begin
            light_total = 0;
            post_reply(STATUS_OK, 0, 1'b0, 1'b1);
         end
         default: begin
            hits = 0;
            for (int unsigned i = 0; i < light_total && hits < MAX_MATCHES; i++) begin
               if (!lights[i].enabled) continue;
               if (lights[i].night_only && !night_on) continue;
               gap2 = sq_gap(r.center_x, lights[i].center_x) +
                      sq_gap(r.center_y, lights[i].center_y) +
                      sq_gap(r.center_z, lights[i].center_z);
               reach = longint'(r.sphere_radius) + longint'(lights[i].radius);
               if (gap2 <= reach * reach) begin
                  found[hits] = i;
                  hits++;
               end
            end
            if (hits == 0) begin
               post_reply(STATUS_OK, 0, 1'b0, 1'b1);
            end else begin
               for (int unsigned k = 0; k < hits; k++) begin
                  post_reply(STATUS_OK, found[k], 1'b1, k == hits - 1);
               end
            end
         end
      endcase
   endfunction

   function automatic void flag_field(string field, logic [7:0] want, logic [7:0] got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fail_count++;
   endfunction

   function automatic void check_reply(slc_rsp_type got);
      slc_rsp_type want;
      if (awaited_rsp_q.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual status %0d slot %0d",
                  $time, got.status, got.slot_index);
         fail_count++;
         return;
      end
      want = awaited_rsp_q.pop_front();
      checked_results++;
      if (got.status !== want.status) flag_field("status", want.status, got.status);
      if (got.slot_index !== want.slot_index)
         flag_field("slot_index", want.slot_index, got.slot_index);
      if (got.match_valid !== want.match_valid)
         flag_field("match_valid", want.match_valid, got.match_valid);
      if (got.light_count !== want.light_count)
         flag_field("light_count", want.light_count, got.light_count);
      if (got.last_result !== want.last_result)
         flag_field("last_result", want.last_result, got.last_result);
   endfunction

   // Results are checked before the request of the same edge is applied, so a
   // result still waiting in the output register meets its own expectation.
   always @(posedge clock) begin
      if (reset) begin
         awaited_rsp_q.delete();
         light_total = 0;
         night_on = 1'b0;
         fail_count = 0;
         checked_results = 0;
         pending_results <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) check_reply(rsp_data);
         if (csr_write_enable) night_on = csr_write_data;
         if (req_valid && !req_stall) replay_light_request(req_data);
         pending_results <= awaited_rsp_q.size();
      end
   end

endmodule

>>> tb/sphere_light_table_cull_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sphere light table cull testbench
// Drives add, remove, clear and query requests into the light table, in day
// and night settings, with bursty requests and a randomly stalling consumer.
// A checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module sphere_light_table_cull_tb;
   import slc_pkg::*;

   localparam int CLK_PERIOD  = 10;
   localparam int CYCLE_LIMIT = 500000;
   localparam int LONG_HOLD   = 400;
   localparam int TAIL_CYCLES = 100;

   localparam logic [COORD_W-1:0] POS_MAX = 24'h7FFFFF;
   localparam logic [COORD_W-1:0] NEG_MIN = 24'h800000;
   localparam logic [COORD_W-1:0] RAD_MAX = 24'hFFFFFF;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   slc_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   slc_rsp_type rsp_data;
   logic        csr_write_enable;
   logic        csr_write_data;

   int fail_count;
   int pending_results;
   int checked_results;
   int cycle_count;
   int requests_sent;
   int queries_sent;
   int long_holds;
   bit long_hold_due;

   always #(CLK_PERIOD / 2) clock = ~clock;

   sphere_light_table_cull i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   light_table_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_results  (pending_results),
      .checked_results  (checked_results)
   );

   // The run is cut off at a generous cycle count in case the block hangs or
   // an expected result never shows up.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // The consumer runs its own stall pattern. When its current style runs out it
   // picks a new one: no stalls at all, light or heavy random stalls, or a regular
   // wave. When the stimulus asks for it, it holds off for a long stretch so
   // that the block backs up and stalls new requests.
   int unsigned hold_left;
   int unsigned mode_left;
   int unsigned stall_mode;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
         mode_left = 0;
         long_hold_due <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (long_hold_due) begin
         rsp_stall <= 1'b1;
         hold_left = LONG_HOLD - 1;
         long_hold_due <= 1'b0;
         long_holds++;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(50, 300);
         end
         mode_left--;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 99) < 30);
            2: rsp_stall <= ($urandom_range(0, 99) < 75);
            default: rsp_stall <= ((mode_left % 7) < 3);
         endcase
      end
   end

   function automatic slc_req_type mk(op_code_type op, logic [COORD_W-1:0] x,
                                      logic [COORD_W-1:0] y, logic [COORD_W-1:0] z,
                                      logic [COORD_W-1:0] rad, logic en, logic night,
                                      logic [5:0] idx);
      slc_req_type r;
      r.req_type        = op;
      r.center_x        = x;
      r.center_y        = y;
      r.center_z        = z;
      r.sphere_radius   = rad;
      r.enabled_flag    = en;
      r.night_only_flag = night;
      r.entry_index     = idx;
      return r;
   endfunction

   // Most coordinates fall in a small cluster around the origin, so that
   // queries hit lights often; the rest span the whole signed range.
   function automatic logic [COORD_W-1:0] pick_coord();
      logic [COORD_W-1:0] v;
      if ($urandom_range(0, 9) < 8) begin
         v = COORD_W'($urandom_range(0, 4095));
         v = v - 24'd2048;
      end else begin
         v = COORD_W'($urandom);
      end
      return v;
   endfunction

   function automatic logic [COORD_W-1:0] pick_radius();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return '0;
      if (roll < 8) return COORD_W'($urandom_range(0, 2047));
      return COORD_W'($urandom);
   endfunction

   function automatic slc_req_type random_request(int unsigned add_pct,
                                                  int unsigned clear_pct);
      int unsigned roll;
      op_code_type op;
      logic [5:0]  idx;
      roll = $urandom_range(0, 99);
      if (roll < add_pct) op = OP_ADD;
      else if (roll < add_pct + clear_pct) op = OP_CLEAR;
      else if (roll % 3 == 0) op = OP_REMOVE;
      else op = OP_QUERY;
      // Removes mostly aim at the low entries that usually exist.
      if ($urandom_range(0, 3) == 0) idx = 6'($urandom_range(0, 63));
      else idx = 6'($urandom_range(0, 7));
      return mk(op, pick_coord(), pick_coord(), pick_coord(), pick_radius(),
                1'($urandom), 1'($urandom), idx);
   endfunction

   // Offers one request and waits until the block takes it. Valid stays high
   // afterwards, so the next request of a burst follows without a gap.
   task automatic send(slc_req_type r);
      req_data  <= r;
      req_valid <= 1'b1;
      requests_sent++;
      if (r.req_type == OP_QUERY) queries_sent++;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic idle(int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Stops offering requests until every predicted result has come back.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
   endtask

   task automatic write_night(logic value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // A stretch of random requests. With gaps on, the sender works in bursts of
   // random length with random pauses between them.
   task automatic run_random(int count, int unsigned add_pct, int unsigned clear_pct,
                             bit with_gaps);
      int unsigned burst_left;
      burst_left = $urandom_range(1, 16);
      for (int n = 0; n < count; n++) begin
         send(random_request(add_pct, clear_pct));
         if (with_gaps) begin
            if (burst_left == 0) begin
               idle($urandom_range(1, 10));
               burst_left = $urandom_range(1, 16);
            end else begin
               burst_left--;
            end
         end
      end
   endtask

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_data         <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= 1'b0;
      requests_sent = 0;
      queries_sent  = 0;
      long_holds    = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part in daytime. The table is empty, so the first query finds
      // nothing and the first remove is out of range.
      write_night(1'b0);
      send(mk(OP_QUERY, '0, '0, '0, 24'h100, 1'b1, 1'b0, '0));
      send(mk(OP_REMOVE, '0, '0, '0, '0, 1'b0, 1'b0, 6'd0));
      // Lights at both corners of the coordinate range, a disabled light, a
      // night-only light, a zero radius light and one that just touches.
      send(mk(OP_ADD, POS_MAX, POS_MAX, POS_MAX, RAD_MAX, 1'b1, 1'b0, '0));
      send(mk(OP_ADD, NEG_MIN, NEG_MIN, NEG_MIN, '0, 1'b1, 1'b0, '0));
      send(mk(OP_ADD, '0, '0, '0, 24'h100, 1'b0, 1'b0, '0));
      send(mk(OP_ADD, '0, '0, '0, 24'h100, 1'b1, 1'b1, '0));
      send(mk(OP_ADD, '0, '0, '0, '0, 1'b1, 1'b0, '0));
      send(mk(OP_ADD, 24'h200, '0, '0, 24'h100, 1'b1, 1'b0, '0));
      // In daytime the disabled and the night-only lights are skipped; the last
      // light overlaps the query sphere exactly at its surface.
      send(mk(OP_QUERY, '0, '0, '0, 24'h100, 1'b0, 1'b0, '0));
      send(mk(OP_QUERY, NEG_MIN, NEG_MIN, NEG_MIN, '0, 1'b0, 1'b0, '0));
      send(mk(OP_QUERY, POS_MAX, POS_MAX, POS_MAX, RAD_MAX, 1'b0, 1'b0, '0));
      send(mk(OP_ADD, '0, '0, 24'hFFFF00, 24'h80, 1'b1, 1'b0, '0));
      send(mk(OP_ADD, POS_MAX, NEG_MIN, '0, RAD_MAX, 1'b1, 1'b0, '0));
      // More overlapping lights than the match limit: the scan stops early.
      send(mk(OP_QUERY, '0, '0, '0, RAD_MAX, 1'b0, 1'b0, '0));
      settle();

      // At night the night-only light takes part.
      write_night(1'b1);
      send(mk(OP_QUERY, '0, '0, '0, 24'h100, 1'b0, 1'b0, '0));
      send(mk(OP_QUERY, '0, '0, '0, '0, 1'b0, 1'b0, '0));
      // Remove from the middle and at the end, then at the count and far out.
      send(mk(OP_REMOVE, '0, '0, '0, '0, 1'b0, 1'b0, 6'd2));
      send(mk(OP_REMOVE, '0, '0, '0, '0, 1'b0, 1'b0, 6'd6));
      send(mk(OP_REMOVE, '0, '0, '0, '0, 1'b0, 1'b0, 6'd6));
      send(mk(OP_REMOVE, '0, '0, '0, '0, 1'b0, 1'b0, 6'd63));
      send(mk(OP_CLEAR, '0, '0, '0, '0, 1'b0, 1'b0, '0));
      send(mk(OP_QUERY, '0, '0, '0, RAD_MAX, 1'b0, 1'b0, '0));
      send(mk(OP_ADD, NEG_MIN, NEG_MIN, NEG_MIN, RAD_MAX, 1'b1, 1'b1, 6'd63));
      send(mk(OP_QUERY, NEG_MIN, NEG_MIN, NEG_MIN, '0, 1'b0, 1'b0, '0));
      settle();

      // Daytime random traffic. The consumer holds off for a long stretch at
      // the start while requests keep coming, so the block backs up.
      write_night(1'b0);
      long_hold_due <= 1'b1;
      run_random(120, 38, 2, 1'b1);
      settle();

      // Night, table filled past its limit, then kept near full with removes
      // at any index. Requests follow back to back here.
      write_night(1'b1);
      send(mk(OP_CLEAR, '0, '0, '0, '0, 1'b0, 1'b0, '0));
      run_random(80, 85, 0, 1'b0);
      run_random(60, 30, 0, 1'b0);
      settle();

      // Daytime again, bursty, with occasional clears.
      write_night(1'b0);
      run_random(120, 38, 2, 1'b1);
      settle();

      // Let any stray result surface before the verdict.
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Covered %0d requests, %0d of them queries, day and night, full table,",
               requests_sent, queries_sent);
      $display("and %0d long consumer hold(s); %0d results compared.",
               long_holds, checked_results);
      if (fail_count == 0 && pending_results == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/slc_pkg.sv
hw/rtl/slc_ram.sv
hw/rtl/slc_overlap.sv
hw/rtl/sphere_light_table_cull.sv
tb/light_table_checker.sv
tb/sphere_light_table_cull_tb.sv
